// ===== sv/arpc_pkg.sv =====
package arpc_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_SWEEP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  localparam int unsigned IP_W       = 32;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LIFETIME_W = 16;
  localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 16'd15;

endpackage

// ===== sv/arpc_ctrl.sv =====
module arpc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  arpc_pkg::sts_t sts,
  output arpc_pkg::cmd_t cmd
);

  arpc_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= arpc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      arpc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = arpc_pkg::ST_WALK;
        end
      end
      arpc_pkg::ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = arpc_pkg::ST_RESULT;
        end
      end
      arpc_pkg::ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = arpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = arpc_pkg::ST_IDLE;
      end
    endcase
    out_valid_next = cmd.finish | (out_valid & out_stall);
  end

endmodule

// ===== sv/arpc_dp.sv =====
module arpc_dp #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  arpc_pkg::cmd_t                        cmd,
  output arpc_pkg::sts_t                        sts,
  input  logic [1:0]                            mode,
  input  logic [arpc_pkg::IP_W-1:0]             ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]            mac_addr,
  input  logic [arpc_pkg::TIME_W-1:0]           now_sec,
  input  logic                                  cfg_we,
  input  logic [arpc_pkg::LIFETIME_W-1:0]       cfg_data,
  output logic                                  success,
  output logic [arpc_pkg::MAC_W-1:0]            found_mac
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [arpc_pkg::IP_W-1:0]       ip_mem    [TABLE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0]      mac_mem   [TABLE_ENTRIES];
  logic [arpc_pkg::TIME_W-1:0]     stamp_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]        used;

  logic [arpc_pkg::LIFETIME_W-1:0] lifetime;
  logic [1:0]                      mode_q;
  logic [arpc_pkg::IP_W-1:0]       ip_q;
  logic [arpc_pkg::MAC_W-1:0]      mac_q;
  logic [arpc_pkg::TIME_W-1:0]     now_q;
  logic [IDX_W-1:0]                idx;
  logic                            hit;
  logic                            placed;
  logic [arpc_pkg::MAC_W-1:0]      hit_mac;

  logic [arpc_pkg::IP_W-1:0]       rd_ip;
  logic [arpc_pkg::MAC_W-1:0]      rd_mac;
  logic [arpc_pkg::TIME_W-1:0]     rd_stamp;

  logic                            last;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  logic [arpc_pkg::TIME_W-1:0]     age;
  logic                            expired;
  logic                            do_insert;
  logic                            do_hit;
  logic                            do_clear;

  assign last     = (idx == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.last = last;
  assign rd_en    = cmd.start | (cmd.step & ~last);
  assign rd_addr  = cmd.start ? '0 : idx + IDX_W'(1);

  assign age     = now_q - rd_stamp;
  assign expired = used[idx] &&
                   (age > {{(arpc_pkg::TIME_W-arpc_pkg::LIFETIME_W){1'b0}}, lifetime});

  always_comb begin
    do_insert = 1'b0;
    do_hit    = 1'b0;
    do_clear  = 1'b0;
    if (cmd.step) begin
      unique case (mode_q)
        arpc_pkg::MODE_INSERT: begin
          do_insert = !placed && !used[idx];
        end
        arpc_pkg::MODE_LOOKUP: begin
          do_clear = expired;
          do_hit   = !expired && !hit && (ip_q != '0) && used[idx] && (rd_ip == ip_q);
        end
        arpc_pkg::MODE_SWEEP: begin
          do_clear = expired;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      ip_mem[idx]  <= ip_q;
      mac_mem[idx] <= mac_q;
    end
    if (do_insert || do_hit) begin
      stamp_mem[idx] <= now_q;
    end
    if (rd_en) begin
      rd_ip    <= ip_mem[rd_addr];
      rd_mac   <= mac_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      lifetime <= arpc_pkg::LIFETIME_RESET;
    end else begin
      if (cfg_we) begin
        lifetime <= cfg_data;
      end
      if (do_insert) begin
        used[idx] <= (ip_q != '0);
      end else if (do_clear) begin
        used[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q  <= mode;
      ip_q    <= ip_addr;
      mac_q   <= mac_addr;
      now_q   <= now_sec;
      idx     <= '0;
      hit     <= 1'b0;
      placed  <= 1'b0;
      hit_mac <= '0;
    end else if (cmd.step) begin
      if (!last) begin
        idx <= idx + IDX_W'(1);
      end
      if (do_insert) begin
        placed <= 1'b1;
      end
      if (do_hit) begin
        hit     <= 1'b1;
        hit_mac <= rd_mac;
      end
    end
    if (cmd.finish) begin
      success   <= placed | hit;
      found_mac <= hit_mac;
    end
  end

endmodule

// ===== sv/arp_cache_with_aging_unit.sv =====
// ARP cache with entry aging: IPv4 -> MAC table with per-entry time stamps.
// Input channel (in_valid/in_stall) carries mode, ip_addr, mac_addr, now_sec.
//   mode 0 inserts into the first free slot, 1 expires old entries then looks
//   up ip_addr and re-stamps the hit, 2 only expires old entries.
// Output channel (out_valid/out_stall) returns success and found_mac, one
//   result transaction per input transaction.
// cfg_we/cfg_data write the entry lifetime (reset value 15); write only when idle.
// The walk visits one table entry per cycle, reading the entry memories at the
//   next address while writing the current one; expiry and match share that
//   one pass. A new transaction is accepted only after the previous one has
//   left its walk and result steps.
// in_stall is low only while idle. The output register lets a new transaction
//   be accepted while a result waits; a held result stalls the next one at
//   its result step until out_stall drops.
// Reset (rst, synchronous) marks all entries free and restores the lifetime;
//   no clearing pass is needed.
module arp_cache_with_aging_unit #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic [arpc_pkg::IP_W-1:0]           ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]          mac_addr,
  input  logic [arpc_pkg::TIME_W-1:0]         now_sec,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                success,
  output logic [arpc_pkg::MAC_W-1:0]          found_mac,
  input  logic                                cfg_we,
  input  logic [arpc_pkg::LIFETIME_W-1:0]     cfg_data
);

  arpc_pkg::cmd_t cmd;
  arpc_pkg::sts_t sts;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  arpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (mode),
    .ip_addr   (ip_addr),
    .mac_addr  (mac_addr),
    .now_sec   (now_sec),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .success   (success),
    .found_mac (found_mac)
  );

endmodule

// ===== sv/arpc_chk.sv =====
module arpc_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       success,
  input logic [arpc_pkg::MAC_W-1:0] found_mac
);

  // a transaction occupies the walk, so the next cycle is always stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  a_miss_zero_mac: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> (found_mac == '0))
    else $error("failed result carries a MAC");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(success) && $stable(found_mac)))
    else $error("stalled result changed");

endmodule

bind arp_cache_with_aging_unit arpc_chk u_arpc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .success   (success),
  .found_mac (found_mac)
);
